[rtl/cdf_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// cdf_pkg
// Shared types and constants of the checksummed frame deframer.
// ----------------------------------------------------------------------------
package cdf_pkg;

  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned OFFSET_W = 9;
  localparam int unsigned CFG_W    = 9;

  localparam logic [BYTE_W-1:0]   COMPLEMENT_SUM = 8'hFF;
  localparam logic [OFFSET_W-1:0] FRAME_OVERHEAD = 9'd3;
  localparam logic [OFFSET_W-1:0] CSUM_LEAD      = 9'd2;
  localparam logic [OFFSET_W-1:0] ABANDON_LEN    = 9'd2;
  localparam logic [OFFSET_W-1:0] MAX_LEN_RESET  = 9'd258;

  localparam logic [OFFSET_W-1:0] OFF_COUNT      = 9'd0;
  localparam logic [OFFSET_W-1:0] OFF_COMPLEMENT = 9'd1;
  localparam logic [OFFSET_W-1:0] OFF_DELIMITER  = 9'd2;

  typedef enum logic {
    REG_DELIMITER = 1'b0,
    REG_MAX_LEN   = 1'b1
  } reg_index_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_CNT_BAD   = 3'd1,
    ST_TOO_LONG  = 3'd2,
    ST_DELIM_BAD = 3'd3,
    ST_CSUM_BAD  = 3'd4
  } status_t;

  typedef struct packed {
    logic [BYTE_W-1:0]   data_byte;
    logic [OFFSET_W-1:0] byte_offset;
    logic                frame_end;
    status_t             status;
    logic [OFFSET_W-1:0] frame_len;
  } result_t;

endpackage
`default_nettype wire

[rtl/cdf_core.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// cdf_core
// Frame tracking state, configuration registers and per-byte result logic.
// ----------------------------------------------------------------------------
module cdf_core (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        cfg_we,
  input  wire logic                        cfg_index,
  input  wire logic [cdf_pkg::CFG_W-1:0]   cfg_data,
  input  wire logic                        take,
  input  wire logic [cdf_pkg::BYTE_W-1:0]  rx_byte,
  output cdf_pkg::result_t                 result
);
  import cdf_pkg::*;

  logic [BYTE_W-1:0]   delimiter_value;
  logic [OFFSET_W-1:0] max_frame_len;

  logic [OFFSET_W-1:0] offset_count, offset_count_next;
  logic [BYTE_W-1:0]   held_count, held_count_next;
  logic [BYTE_W-1:0]   running_sum, running_sum_next;
  logic                delimiter_bad, delimiter_bad_next;

  logic [BYTE_W-1:0]   header_sum;
  logic [OFFSET_W-1:0] full_len;
  logic [OFFSET_W-1:0] last_off;
  logic                delim_bad_now;

  always_ff @(posedge clk) begin
    if (rst) begin
      delimiter_value <= '0;
      max_frame_len   <= MAX_LEN_RESET;
    end else if (cfg_we) begin
      case (reg_index_t'(cfg_index))
        REG_DELIMITER: delimiter_value <= cfg_data[BYTE_W-1:0];
        REG_MAX_LEN:   max_frame_len   <= cfg_data[OFFSET_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      offset_count  <= '0;
      held_count    <= '0;
      running_sum   <= '0;
      delimiter_bad <= 1'b0;
    end else if (take) begin
      offset_count  <= offset_count_next;
      held_count    <= held_count_next;
      running_sum   <= running_sum_next;
      delimiter_bad <= delimiter_bad_next;
    end
  end

  always_comb begin
    header_sum    = held_count + rx_byte;
    full_len      = {1'b0, held_count} + FRAME_OVERHEAD;
    last_off      = {1'b0, held_count} + CSUM_LEAD;
    delim_bad_now = (offset_count == OFF_DELIMITER) ? (rx_byte != delimiter_value)
                                                    : delimiter_bad;

    offset_count_next  = offset_count;
    held_count_next    = held_count;
    running_sum_next   = running_sum;
    delimiter_bad_next = delimiter_bad;

    result.data_byte   = rx_byte;
    result.byte_offset = offset_count;
    result.frame_end   = 1'b0;
    result.status      = ST_OK;
    result.frame_len   = '0;

    if (offset_count == OFF_COUNT) begin
      held_count_next    = rx_byte;
      running_sum_next   = rx_byte;
      delimiter_bad_next = 1'b0;
      offset_count_next  = OFF_COMPLEMENT;
    end else if (offset_count == OFF_COMPLEMENT) begin
      if (header_sum != COMPLEMENT_SUM) begin
        result.frame_end  = 1'b1;
        result.status     = ST_CNT_BAD;
        result.frame_len  = ABANDON_LEN;
        offset_count_next = OFF_COUNT;
      end else if (full_len > max_frame_len) begin
        result.frame_end  = 1'b1;
        result.status     = ST_TOO_LONG;
        result.frame_len  = ABANDON_LEN;
        offset_count_next = OFF_COUNT;
      end else begin
        running_sum_next  = running_sum + rx_byte;
        offset_count_next = OFF_DELIMITER;
      end
    end else begin
      delimiter_bad_next = delim_bad_now;
      if (offset_count >= last_off) begin
        result.frame_end  = 1'b1;
        result.frame_len  = full_len;
        if (delim_bad_now) begin
          result.status = ST_DELIM_BAD;
        end else if (running_sum != rx_byte) begin
          result.status = ST_CSUM_BAD;
        end else begin
          result.status = ST_OK;
        end
        offset_count_next = OFF_COUNT;
      end else begin
        running_sum_next  = running_sum + rx_byte;
        offset_count_next = offset_count + 9'd1;
      end
    end
  end

endmodule
`default_nettype wire

[rtl/cdf_out_skid.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// cdf_out_skid
// Result register with one skid word so the input side keeps flowing.
// ----------------------------------------------------------------------------
module cdf_out_skid (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push_valid,
  output logic                   push_ready,
  input  wire cdf_pkg::result_t  push_word,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output cdf_pkg::result_t       out_word
);
  import cdf_pkg::*;

  result_t skid_word;
  logic    skid_valid;
  logic    take;

  assign push_ready = !skid_valid;
  assign take       = push_valid && push_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_ready || !out_valid) begin
      out_valid  <= skid_valid || take;
      skid_valid <= 1'b0;
    end else if (take) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready || !out_valid) begin
      if (skid_valid) begin
        out_word <= skid_word;
      end else if (take) begin
        out_word <= push_word;
      end
    end else if (take) begin
      skid_word <= push_word;
    end
  end

endmodule
`default_nettype wire

[rtl/checksummed_frame_deframer_top.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// checksummed_frame_deframer_top
// Received bytes go in on in_valid/in_ready, one word per byte. Every byte
// comes back on out_valid/out_ready with its offset in the frame; frame_end,
// status and frame_len mark the byte where a frame completes or is dropped.
// A frame is count, complement of count, delimiter, body, checksum.
// Each accepted byte's result is registered in the output stage; throughput is
// one byte per cycle while in_ready is high, set by the update of the frame
// state register. The configuration port (cfg_we, cfg_index, cfg_data) writes
// the delimiter value (index 0) and the maximum frame length (index 1).
// Reset clears the frame state (next byte is a count byte), the output
// stage, and sets the delimiter to 0 and the maximum length to 258.
// When the receiver stalls, the result register holds its word and one more
// word is caught in a skid register; in_ready then drops until the
// receiver takes a word.
// ----------------------------------------------------------------------------
module checksummed_frame_deframer_top (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        cfg_we,
  input  wire logic                        cfg_index,
  input  wire logic [cdf_pkg::CFG_W-1:0]   cfg_data,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [cdf_pkg::BYTE_W-1:0]  rx_byte,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [cdf_pkg::BYTE_W-1:0]       data_byte,
  output logic [cdf_pkg::OFFSET_W-1:0]     byte_offset,
  output logic                             frame_end,
  output logic [2:0]                       status,
  output logic [cdf_pkg::OFFSET_W-1:0]     frame_len
);
  import cdf_pkg::*;

  result_t core_word;
  result_t out_word;
  logic    take;

  assign take = in_valid && in_ready;

  cdf_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .take      (take),
    .rx_byte   (rx_byte),
    .result    (core_word)
  );

  cdf_out_skid u_out (
    .clk        (clk),
    .rst        (rst),
    .push_valid (in_valid),
    .push_ready (in_ready),
    .push_word  (core_word),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_word   (out_word)
  );

  assign data_byte   = out_word.data_byte;
  assign byte_offset = out_word.byte_offset;
  assign frame_end   = out_word.frame_end;
  assign status      = out_word.status;
  assign frame_len   = out_word.frame_len;

endmodule
`default_nettype wire
